FILE: rtl/hbfns_pkg.sv
`timescale 1ns / 1ps

package hbfns_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned LogWay   = 6;
  localparam int unsigned PosW     = 18;
  localparam int unsigned SizeW    = 19;
  localparam int unsigned LeafAw   = 12;
  localparam int unsigned MidAw    = 6;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [SizeW-1:0] SizeReset = 19'd262144;

  localparam logic ModeSet  = 1'b0;
  localparam logic ModeFind = 1'b1;

  localparam logic RegSizeBits = 1'b0;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
    logic            rejected;
  } result_t;

  function automatic logic [LogWay-1:0] low_bit(input logic [WordW-1:0] w);
    logic [LogWay-1:0] n;
    n = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (w[i]) begin
        n = i[LogWay-1:0];
      end
    end
    return n;
  endfunction

  function automatic logic [WordW-1:0] mask_from(input logic [LogWay-1:0] k);
    return {WordW{1'b1}} << k;
  endfunction

  function automatic logic [WordW-1:0] mask_above(input logic [LogWay-1:0] k);
    return ({WordW{1'b1}} << k) << 1;
  endfunction

endpackage

FILE: rtl/hbfns_if.sv
`timescale 1ns / 1ps

interface hbfns_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [hbfns_pkg::PosW-1:0] bit_index;

  modport source (output valid, output mode, output bit_index, input ready);
  modport sink (input valid, input mode, input bit_index, output ready);
endinterface

interface hbfns_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [hbfns_pkg::PosW-1:0] position;
  logic                      rejected;

  modport source (output valid, output found, output position, output rejected, input ready);
  modport sink (input valid, input found, input position, input rejected, output ready);
endinterface

FILE: rtl/hier_bitmap_find_next_set.sv
`timescale 1ns / 1ps

// A 262144-position bitmap kept as a three-level pyramid of 64-bit words: a 4096-word
// leaf memory, a 64-word summary memory and a top word in flip-flops. A set transfer
// marks one position; a find transfer returns the first set position at or after the
// given index that lies below size_bits. Items are handled one at a time. A refused item
// goes straight to the output step; a set, or a find that hits in its own leaf word,
// passes through the summary and leaf reads, and a find that moves on to a later leaf
// word walks down again, reading the summary memory first when it must move to a later
// summary word and then the leaf memory, because each level of the walk waits on one
// registered read of the summary or leaf memory. The input is ready again on the cycle
// after the result is loaded. The result sits in an output register, so a new item is
// taken while it waits; a result still waiting there holds the next one back. Reset
// clears the pyramid at once: a leaf or summary word counts as written only when its
// bit in the level above is set, so no clearing pass is needed.
module hier_bitmap_find_next_set (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hbfns_in_if.sink                          in_i,
  hbfns_out_if.source                       out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hbfns_pkg::CfgAddrW-1:0]    paddr,
  input  logic [hbfns_pkg::CfgDataW-1:0]    pwdata,
  output logic [hbfns_pkg::CfgDataW-1:0]    prdata,
  output logic                              pready
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMid   = 3'd1;
  localparam logic [2:0] StLeaf  = 3'd2;
  localparam logic [2:0] StMDesc = 3'd3;
  localparam logic [2:0] StLDesc = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]                          state_q, state_d;
  logic                                mode_q, mode_d;
  logic [hbfns_pkg::PosW-1:0]          idx_q, idx_d;
  logic [hbfns_pkg::WordW-1:0]         mword_q, mword_d;
  logic [hbfns_pkg::LeafAw-1:0]        desc_q, desc_d;
  logic [hbfns_pkg::WordW-1:0]         top_q, top_d;
  logic [hbfns_pkg::SizeW-1:0]         size_q;
  hbfns_pkg::result_t                  res_q, res_d;
  hbfns_pkg::result_t                  out_res_q;
  logic                                out_valid_q;
  logic                                out_load;

  logic [hbfns_pkg::WordW-1:0]         leaf_mem [2**hbfns_pkg::LeafAw];
  logic [hbfns_pkg::WordW-1:0]         mid_mem [2**hbfns_pkg::MidAw];
  logic [hbfns_pkg::WordW-1:0]         leaf_rdata_q, mid_rdata_q;
  logic [hbfns_pkg::LeafAw-1:0]        leaf_raddr, leaf_waddr;
  logic [hbfns_pkg::MidAw-1:0]         mid_raddr, mid_waddr;
  logic [hbfns_pkg::WordW-1:0]         leaf_wdata, mid_wdata;
  logic                                leaf_we, mid_we;

  logic [hbfns_pkg::WordW-1:0]         mid_eff, leaf_eff, leaf_hits, mid_hits, top_hits;

  function automatic hbfns_pkg::result_t hit_result(
    input logic [hbfns_pkg::PosW-1:0]  hit,
    input logic [hbfns_pkg::SizeW-1:0] size
  );
    hbfns_pkg::result_t r;
    r = '0;
    if ({1'b0, hit} < size) begin
      r.found    = 1'b1;
      r.position = hit;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[leaf_waddr] <= leaf_wdata;
    end
    leaf_rdata_q <= leaf_mem[leaf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mid_we) begin
      mid_mem[mid_waddr] <= mid_wdata;
    end
    mid_rdata_q <= mid_mem[mid_raddr];
  end

  assign mid_eff   = top_q[idx_q[17:12]] ? mid_rdata_q : '0;
  assign leaf_eff  = mword_q[idx_q[11:6]] ? leaf_rdata_q : '0;
  assign leaf_hits = leaf_eff & hbfns_pkg::mask_from(idx_q[5:0]);
  assign mid_hits  = mword_q & hbfns_pkg::mask_above(idx_q[11:6]);
  assign top_hits  = top_q & hbfns_pkg::mask_above(idx_q[17:12]);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    idx_d      = idx_q;
    mword_d    = mword_q;
    desc_d     = desc_q;
    top_d      = top_q;
    res_d      = res_q;
    out_load   = 1'b0;
    in_i.ready = 1'b0;
    leaf_raddr = idx_q[17:6];
    mid_raddr  = idx_q[17:12];
    leaf_we    = 1'b0;
    leaf_waddr = idx_q[17:6];
    leaf_wdata = leaf_eff | (64'd1 << idx_q[5:0]);
    mid_we     = 1'b0;
    mid_waddr  = idx_q[17:12];
    mid_wdata  = mword_q | (64'd1 << idx_q[11:6]);
    case (state_q)
      StIdle: begin
        in_i.ready = 1'b1;
        mid_raddr  = in_i.bit_index[17:12];
        if (in_i.valid) begin
          idx_d  = in_i.bit_index;
          mode_d = in_i.mode;
          if ({1'b0, in_i.bit_index} >= size_q) begin
            res_d          = '0;
            res_d.rejected = 1'b1;
            state_d        = StOut;
          end else begin
            state_d = StMid;
          end
        end
      end
      StMid: begin
        mword_d = mid_eff;
        state_d = StLeaf;
      end
      StLeaf: begin
        state_d = StOut;
        res_d   = '0;
        if (mode_q == hbfns_pkg::ModeSet) begin
          leaf_we = 1'b1;
          mid_we  = 1'b1;
          top_d   = top_q | (64'd1 << idx_q[17:12]);
        end else if (|leaf_hits) begin
          res_d = hit_result({idx_q[17:6], hbfns_pkg::low_bit(leaf_hits)}, size_q);
        end else if (|mid_hits) begin
          desc_d     = {idx_q[17:12], hbfns_pkg::low_bit(mid_hits)};
          leaf_raddr = desc_d;
          state_d    = StLDesc;
        end else if (|top_hits) begin
          desc_d    = {hbfns_pkg::low_bit(top_hits), 6'd0};
          mid_raddr = hbfns_pkg::low_bit(top_hits);
          state_d   = StMDesc;
        end
      end
      StMDesc: begin
        desc_d     = {desc_q[11:6], hbfns_pkg::low_bit(mid_rdata_q)};
        leaf_raddr = desc_d;
        state_d    = StLDesc;
      end
      StLDesc: begin
        res_d   = hit_result({desc_q, hbfns_pkg::low_bit(leaf_rdata_q)}, size_q);
        state_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      top_q       <= '0;
      size_q      <= hbfns_pkg::SizeReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      if (psel && penable && pwrite && pready && paddr[2] == hbfns_pkg::RegSizeBits) begin
        size_q <= pwdata[hbfns_pkg::SizeW-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    idx_q   <= idx_d;
    mword_q <= mword_d;
    desc_q  <= desc_d;
    res_q   <= res_d;
    if (out_load) begin
      out_res_q <= res_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.found    = out_res_q.found;
  assign out_o.position = out_res_q.position;
  assign out_o.rejected = out_res_q.rejected;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == hbfns_pkg::RegSizeBits) ?
                  {{(hbfns_pkg::CfgDataW - hbfns_pkg::SizeW){1'b0}}, size_q} : '0;

endmodule

FILE: rtl/hbfns_chk.sv
`timescale 1ns / 1ps

module hbfns_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        found_i,
  input logic                        rejected_i,
  input logic [hbfns_pkg::PosW-1:0]  position_i
);

  // Only one item is in flight, so the input closes right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready after a transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(found_i && rejected_i))
    else $error("result both found and rejected");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> position_i == '0)
    else $error("nonzero position without a hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(position_i) && $stable(found_i))
    else $error("stalled result changed");

endmodule

bind hier_bitmap_find_next_set hbfns_chk u_hbfns_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .found_i    (out_o.found),
  .rejected_i (out_o.rejected),
  .position_i (out_o.position)
);
